// File: hw/rtl/tcw_pkg.sv
package tcw_pkg;

	// default screen geometry
	localparam int COLS_DEF = 80;
	localparam int ROWS_DEF = 25;

	// field widths
	localparam int REQ_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int X_W      = 7;
	localparam int Y_W      = 5;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = CHAR_W + COLOR_W;

	// request types
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

	// console control characters
	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam int TAB_STEP = 4;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] cell_color;
		logic [X_W-1:0]     col_x;
		logic [Y_W-1:0]     row_y;
	} req_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_index;
		logic [CHAR_W-1:0]   read_char;
	} res_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_PRINT,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_TAB,
		OP_WRITE,
		OP_READ,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAR_W-1:0]  char_code;
		logic [COLOR_W-1:0] cell_color;
		logic [X_W-1:0]     col_x;
		logic [Y_W-1:0]     row_y;
	} q_entry_t;

	typedef enum logic [2:0] {
		BS_INIT,
		BS_IDLE,
		BS_READ,
		BS_SCROLL,
		BS_CLEAR
	} back_state_t;

endpackage

// File: hw/rtl/text_console_writer.sv
// Text console writer: a COLS x ROWS character screen with a cursor.
//
// Commands enter on start/req: a command is taken at a rising edge with
// start high and busy low. req carries the request type (put char at
// cursor, write cell, read char, clear), the character, the cell color
// and the cell position. Each command returns exactly one result on
// result, valid for the single cycle in which done is high; the receiver
// cannot stall, so every result is taken as it appears.
//
// A front end classifies commands into a two-entry queue; the back end
// executes them against the cell RAM. For put, write and ignored commands
// the result passes the queue and the result register; a read also waits
// for the registered RAM read port. A put that runs past the last row
// scrolls the screen: the row copy plus blank fill sweeps the whole cell
// RAM through its one write port, as does a clear. Plain puts sustain one
// command per cycle while no scroll or clear holds the back end.
//
// After reset the cell RAM is filled with blanks in color 7, one cell per
// cycle; busy stays high meanwhile. The text color register takes a
// transfer on cfg_valid with cfg_ready, which is always high; write it
// only while no command is outstanding.
module text_console_writer #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  tcw_pkg::req_t               req,
	output logic                        busy,
	output logic                        done,
	output tcw_pkg::res_t               result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tcw_pkg::COLOR_W-1:0] cfg_data
);

	logic [tcw_pkg::COLOR_W-1:0] text_color_q;
	logic                        init_busy;
	logic                        pop;
	logic                        ent_valid;
	tcw_pkg::q_entry_t           ent;

	// the color register can take a transfer at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tcw_pkg::RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// front end: accept, classify, queue
	tcw_front #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.init_busy (init_busy),
		.busy      (busy),
		.pop       (pop),
		.ent_valid (ent_valid),
		.ent       (ent)
	);

	// back end: cursor, cell RAM, scroll and clear sweeps
	tcw_back #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.ent_valid  (ent_valid),
		.ent        (ent),
		.pop        (pop),
		.init_busy  (init_busy),
		.done       (done),
		.result     (result)
	);

endmodule

// File: hw/rtl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/tcw_front.sv
module tcw_front #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tcw_pkg::req_t     req,
	input  logic              init_busy,
	output logic              busy,
	input  logic              pop,
	output logic              ent_valid,
	output tcw_pkg::q_entry_t ent
);

	tcw_pkg::q_entry_t              ent_q [tcw_pkg::QDEPTH];
	logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]     count_q;
	tcw_pkg::q_entry_t              new_ent;
	logic                           push;
	logic                           do_pop;
	logic                           in_range;

	assign busy      = (count_q == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH)) || init_busy;
	assign push      = start && !busy;
	assign ent_valid = (count_q != '0);
	assign do_pop    = pop && ent_valid;
	assign ent       = ent_q[rd_ptr_q];
	assign in_range  = (int'(req.col_x) < COLS) && (int'(req.row_y) < ROWS);

	// classify the request so the back end only executes
	always_comb begin
		new_ent.char_code  = req.char_code;
		new_ent.cell_color = req.cell_color;
		new_ent.col_x      = req.col_x;
		new_ent.row_y      = req.row_y;
		new_ent.op         = tcw_pkg::OP_NOP;
		unique case (req.req_type)
			tcw_pkg::REQ_PUT: begin
				unique case (req.char_code)
					tcw_pkg::CH_NUL:       new_ent.op = tcw_pkg::OP_NOP;
					tcw_pkg::CH_NEWLINE:   new_ent.op = tcw_pkg::OP_NEWLINE;
					tcw_pkg::CH_BACKSPACE: new_ent.op = tcw_pkg::OP_BACKSPACE;
					tcw_pkg::CH_TAB:       new_ent.op = tcw_pkg::OP_TAB;
					default:               new_ent.op = tcw_pkg::OP_PRINT;
				endcase
			end
			tcw_pkg::REQ_WRITE: new_ent.op = in_range ? tcw_pkg::OP_WRITE : tcw_pkg::OP_NOP;
			tcw_pkg::REQ_READ:  new_ent.op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
			default:            new_ent.op = tcw_pkg::OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/tcw_back.sv
module tcw_back #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
	input  logic                          ent_valid,
	input  tcw_pkg::q_entry_t             ent,
	output logic                          pop,
	output logic                          init_busy,
	output logic                          done,
	output tcw_pkg::res_t                 result
);

	localparam int CELLS  = COLS * ROWS;
	localparam int COPY_N = CELLS - COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int COL_W  = $clog2(COLS);
	localparam int ROW_W  = $clog2(ROWS);

	tcw_pkg::back_state_t state_q, state_d;
	logic [ROW_W-1:0]     row_q, row_d;
	logic [COL_W-1:0]     col_q, col_d;
	logic [ADDR_W-1:0]    base_q, base_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic                 done_q, done_d;
	tcw_pkg::res_t        res_q;
	logic [tcw_pkg::CHAR_W-1:0] rchar_d;

	logic                       we;
	logic [ADDR_W-1:0]          waddr;
	logic [tcw_pkg::CELL_W-1:0] wdata;
	logic [ADDR_W-1:0]          raddr;
	logic [tcw_pkg::CELL_W-1:0] rdata;

	logic [ADDR_W-1:0]          cursor_addr;
	logic [ADDR_W-1:0]          cell_addr;
	logic [ADDR_W-1:0]          lin_d;
	logic [tcw_pkg::CELL_W-1:0] blank;
	logic                       adv_col;
	logic [COL_W:0]             step;
	logic [COL_W:0]             colsum;
	logic                       wrap;

	assign cursor_addr = base_q + ADDR_W'(col_q);
	assign cell_addr   = ADDR_W'(ent.row_y) * ADDR_W'(COLS) + ADDR_W'(ent.col_x);
	assign blank       = {text_color, tcw_pkg::CH_BLANK};
	assign lin_d       = base_d + ADDR_W'(col_d);
	assign init_busy   = (state_q == tcw_pkg::BS_INIT);

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		base_d  = base_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		rchar_d = '0;
		pop     = 1'b0;
		we      = 1'b0;
		waddr   = cursor_addr;
		wdata   = blank;
		raddr   = cell_addr;
		adv_col = 1'b0;
		step    = '0;
		colsum  = '0;
		wrap    = 1'b0;
		unique case (state_q)
			tcw_pkg::BS_INIT: begin
				we    = 1'b1;
				waddr = ADDR_W'(cnt_q);
				wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::CH_BLANK};
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					cnt_d   = '0;
					state_d = tcw_pkg::BS_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::BS_IDLE: begin
				if (ent_valid) begin
					pop = 1'b1;
					unique case (ent.op)
						tcw_pkg::OP_NOP: done_d = 1'b1;
						tcw_pkg::OP_PRINT: begin
							we      = 1'b1;
							wdata   = {text_color, ent.char_code};
							adv_col = 1'b1;
							step    = (COL_W+1)'(1);
							done_d  = 1'b1;
						end
						tcw_pkg::OP_TAB: begin
							adv_col = 1'b1;
							step    = (COL_W+1)'(tcw_pkg::TAB_STEP);
							done_d  = 1'b1;
						end
						tcw_pkg::OP_NEWLINE: begin
							col_d  = '0;
							wrap   = 1'b1;
							done_d = 1'b1;
						end
						tcw_pkg::OP_BACKSPACE: begin
							// step back, then blank the cell under the new cursor
							we = 1'b1;
							if (col_q != '0) begin
								col_d = col_q - 1'b1;
								waddr = cursor_addr - 1'b1;
							end else if (row_q != '0) begin
								row_d  = row_q - 1'b1;
								base_d = base_q - ADDR_W'(COLS);
								waddr  = base_q - ADDR_W'(COLS);
							end
							done_d = 1'b1;
						end
						tcw_pkg::OP_WRITE: begin
							we     = 1'b1;
							waddr  = cell_addr;
							wdata  = {ent.cell_color, ent.char_code};
							done_d = 1'b1;
						end
						tcw_pkg::OP_READ: begin
							state_d = tcw_pkg::BS_READ;
						end
						tcw_pkg::OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							base_d  = '0;
							cnt_d   = '0;
							state_d = tcw_pkg::BS_CLEAR;
						end
					endcase
					if (adv_col) begin
						colsum = {1'b0, col_q} + step;
						if (colsum >= (COL_W+1)'(COLS)) begin
							col_d = '0;
							wrap  = 1'b1;
						end else begin
							col_d = colsum[COL_W-1:0];
						end
					end
					if (wrap) begin
						if (row_q == ROW_W'(ROWS - 1)) begin
							// hold the result until the scroll is done
							done_d  = 1'b0;
							cnt_d   = '0;
							state_d = tcw_pkg::BS_SCROLL;
						end else begin
							row_d  = row_q + 1'b1;
							base_d = base_q + ADDR_W'(COLS);
						end
					end
				end
			end
			tcw_pkg::BS_READ: begin
				done_d  = 1'b1;
				rchar_d = rdata[tcw_pkg::CHAR_W-1:0];
				state_d = tcw_pkg::BS_IDLE;
			end
			tcw_pkg::BS_SCROLL: begin
				// read one row ahead, write back the cell read last cycle, then blank the last row
				if (cnt_q < CNT_W'(COPY_N)) begin
					raddr = ADDR_W'(cnt_q + CNT_W'(COLS));
				end
				if (cnt_q != '0) begin
					we    = 1'b1;
					waddr = ADDR_W'(cnt_q - 1'b1);
					wdata = (cnt_q <= CNT_W'(COPY_N)) ? rdata : blank;
				end
				if (cnt_q == CNT_W'(CELLS)) begin
					cnt_d   = '0;
					done_d  = 1'b1;
					state_d = tcw_pkg::BS_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tcw_pkg::BS_CLEAR: begin
				we    = 1'b1;
				waddr = ADDR_W'(cnt_q);
				if (cnt_q == CNT_W'(CELLS - 1)) begin
					cnt_d   = '0;
					done_d  = 1'b1;
					state_d = tcw_pkg::BS_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = tcw_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::BS_INIT;
			row_q   <= '0;
			col_q   <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			if (done_d) begin
				res_q.cursor_index <= tcw_pkg::CURSOR_W'(lin_d);
				res_q.read_char    <= rchar_d;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// File: hw/rtl/tcw_checker.sv
module tcw_checker #(
	parameter int COLS = tcw_pkg::COLS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input tcw_pkg::res_t               result
);

	localparam int CELLS = COLS * ROWS;
	localparam int LIMIT = (CELLS > 2048) ? 2048 : CELLS;

	logic [2:0] pend_q;
	logic       acc;

	assign acc = start && !busy;

	// count commands transferred but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(acc) - 3'(done);
		end
	end

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pend_q != '0))
		else $error("result without an outstanding command");

	a_pend_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more commands outstanding than the block can hold");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(result))
		else $error("result changed without done");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(result.cursor_index) < LIMIT))
		else $error("cursor index beyond the screen");

	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> busy)
		else $error("command accepted during the reset fill");

endmodule

bind text_console_writer tcw_checker #(
	.COLS (COLS),
	.ROWS (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.result    (result)
);

// File: bench/text_console_writer_tb.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	// Screen geometry under test and derived sizes
	localparam int COLS   = COLS_DEF;
	localparam int ROWS   = ROWS_DEF;
	localparam int CELLS  = COLS * ROWS;
	// Longest internal sweep (scroll or clear) plus some margin
	localparam int SETTLE = CELLS + 16;

	// Clock, reset and the block's inputs, all known from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	req_t               req       = '0;
	logic               cfg_valid = 1'b0;
	logic [COLOR_W-1:0] cfg_data  = '0;

	logic busy;
	logic done;
	res_t result;
	logic cfg_ready;

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the console: cell store, cursor and text color
	logic [CELL_W-1:0]  shadow_cells [CELLS];
	int                 shadow_row;
	int                 shadow_col;
	logic [COLOR_W-1:0] shadow_color;

	// Results owed by the block, oldest first
	res_t pending_results [$];

	int error_count = 0;
	int burst_left  = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Hang guard: far beyond the slowest legal run (every item scrolling)
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Console predictor
	// ------------------------------------------------------------------

	function automatic logic [CELL_W-1:0] blank_cell();
		return {shadow_color, CH_BLANK};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = blank_cell();
	endfunction

	// Move every line up by one and blank the bottom line
	function automatic void scroll_screen();
		for (int i = 0; i < COLS * (ROWS - 1); i++)
			shadow_cells[i] = shadow_cells[i + COLS];
		for (int i = 0; i < COLS; i++)
			shadow_cells[COLS * (ROWS - 1) + i] = blank_cell();
		shadow_row = ROWS - 1;
	endfunction

	function automatic void put_at_cursor(input logic [CHAR_W-1:0] ch);
		if (ch == CH_NUL)
			return;
		if (ch == CH_NEWLINE) begin
			shadow_col = 0;
			shadow_row++;
		end else if (ch == CH_BACKSPACE) begin
			// back one column, or up to column 0 of the row above; stop at the origin
			if (shadow_col > 0)
				shadow_col--;
			else if (shadow_row > 0)
				shadow_row--;
			shadow_cells[shadow_row * COLS + shadow_col] = blank_cell();
		end else if (ch == CH_TAB) begin
			shadow_col += TAB_STEP;
		end else begin
			shadow_cells[shadow_row * COLS + shadow_col] = {shadow_color, ch};
			shadow_col++;
		end
		if (shadow_col >= COLS) begin
			shadow_col = 0;
			shadow_row++;
		end
		if (shadow_row >= ROWS)
			scroll_screen();
	endfunction

	// Apply one request to the shadow console and return what the block owes
	function automatic res_t console_step(input req_t r);
		res_t res;
		int   x;
		int   y;
		logic in_range;
		x = int'(r.col_x);
		y = int'(r.row_y);
		in_range = (x < COLS) && (y < ROWS);
		res.read_char = '0;
		case (r.req_type)
			REQ_PUT: begin
				put_at_cursor(r.char_code);
			end
			REQ_WRITE: begin
				if (in_range)
					shadow_cells[y * COLS + x] = {r.cell_color, r.char_code};
			end
			REQ_READ: begin
				if (in_range)
					res.read_char = shadow_cells[y * COLS + x][CHAR_W-1:0];
			end
			default: begin
				blank_screen();
				shadow_row = 0;
				shadow_col = 0;
			end
		endcase
		res.cursor_index = CURSOR_W'(shadow_row * COLS + shadow_col);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// Take each result at the edge that ends its strobe cycle
	initial begin : result_checker
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && done) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result cursor %0d char %0d",
						result.cursor_index, result.read_char));
				end else begin
					want = pending_results.pop_front();
					if (result.cursor_index !== want.cursor_index)
						report_mismatch($sformatf("cursor_index got %0d, expected %0d",
							result.cursor_index, want.cursor_index));
					if (result.read_char !== want.read_char)
						report_mismatch($sformatf("read_char got 0x%02h, expected 0x%02h",
							result.read_char, want.read_char));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Gap before the next command: mostly none or short, a few long,
	// and now and then a whole run of back-to-back commands
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(input logic [REQ_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] color,
			input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
		req_t r;
		r.req_type   = kind;
		r.char_code  = ch;
		r.cell_color = color;
		r.col_x      = x;
		r.row_y      = y;
		return r;
	endfunction

	// Byte for a put: control characters weighted up, any byte otherwise
	function automatic logic [CHAR_W-1:0] pick_char(input int newline_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < newline_pct)
			return CH_NEWLINE;
		r = $urandom_range(0, 99);
		if (r < 6)
			return CH_TAB;
		if (r < 12)
			return CH_BACKSPACE;
		if (r < 15)
			return CH_NUL;
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// Cell position: mostly on screen, sometimes any encodable value
	function automatic req_t place_cell(input req_t r);
		if ($urandom_range(0, 99) < 85) begin
			r.col_x = X_W'($urandom_range(0, COLS - 1));
			r.row_y = Y_W'($urandom_range(0, ROWS - 1));
		end else begin
			r.col_x = X_W'($urandom);
			r.row_y = Y_W'($urandom);
		end
		return r;
	endfunction

	function automatic req_t random_fields(input logic [REQ_W-1:0] kind);
		return make_req(kind, CHAR_W'($urandom), COLOR_W'($urandom),
			X_W'($urandom), Y_W'($urandom));
	endfunction

	// Present one command and hold it until the block takes it
	task automatic send_req(input req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		pending_results.push_back(console_step(item));
	endtask

	// Drop start, drain all owed results, then let any sweep run out
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_text_color(input logic [COLOR_W-1:0] color);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= color;
		do @(posedge clk); while (!cfg_ready);
		shadow_color = color;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// The reset sweep must leave blanks in the first and last cell, cursor at the origin
	task automatic test_reset_screen();
		send_req(make_req(REQ_READ, '0, '0, '0, '0));
		send_req(make_req(REQ_READ, '1, '1, X_W'(COLS - 1), Y_W'(ROWS - 1)));
	endtask

	// Every put case: the top byte 0xFF, the digit zero, ignored zero byte,
	// tab, newline, backspace within a row, across a row and at the origin
	task automatic test_put_controls();
		send_req(make_req(REQ_PUT, 8'hFF, '0, '0, '0));
		send_req(make_req(REQ_PUT, 8'h30, '1, '1, '1));
		send_req(make_req(REQ_PUT, CH_NUL, '1, '1, '1));
		send_req(make_req(REQ_READ, '0, '0, 7'd0, 5'd0));
		send_req(make_req(REQ_READ, '0, '0, 7'd1, 5'd0));
		send_req(make_req(REQ_PUT, CH_TAB, '0, '0, '0));
		send_req(make_req(REQ_PUT, CH_BACKSPACE, '0, '0, '0));
		send_req(make_req(REQ_PUT, CH_NEWLINE, '0, '0, '0));
		send_req(make_req(REQ_PUT, CH_BACKSPACE, '0, '0, '0));
		send_req(make_req(REQ_PUT, CH_BACKSPACE, '0, '0, '0));
		send_req(make_req(REQ_READ, '0, '0, 7'd0, 5'd0));
	endtask

	// Cell writes and reads at the corners, a stored zero byte, and
	// positions off the screen, which write nothing and read zero
	task automatic test_cell_extremes();
		send_req(make_req(REQ_WRITE, 8'h00, 8'hFF, X_W'(COLS - 1), Y_W'(ROWS - 1)));
		send_req(make_req(REQ_READ, '0, '0, X_W'(COLS - 1), Y_W'(ROWS - 1)));
		send_req(make_req(REQ_WRITE, 8'hFF, 8'h00, 7'd0, 5'd0));
		send_req(make_req(REQ_READ, '0, '0, 7'd0, 5'd0));
		send_req(make_req(REQ_WRITE, 8'hAA, 8'h55, '1, '1));
		send_req(make_req(REQ_READ, '1, '1, '1, '1));
		send_req(make_req(REQ_READ, '0, '0, X_W'(COLS), 5'd0));
		send_req(make_req(REQ_READ, '0, '0, 7'd0, Y_W'(ROWS)));
	endtask

	task automatic test_clear_screen();
		send_req(make_req(REQ_CLEAR, '1, '1, '1, '1));
		send_req(make_req(REQ_READ, '0, '0, X_W'(COLS - 1), Y_W'(ROWS - 1)));
	endtask

	// Running text: mostly puts, so the cursor wraps rows and scrolls the
	// screen; reads aimed just behind the cursor check what was printed
	task automatic test_text_stream(input int count, input int newline_pct);
		req_t r;
		int   pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 82) begin
				r = random_fields(REQ_PUT);
				r.char_code = pick_char(newline_pct);
			end else if (pick < 92) begin
				r = random_fields(REQ_READ);
				r.col_x = X_W'((shadow_col > 0) ? shadow_col - 1 : 0);
				r.row_y = Y_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, ROWS - 1)
					: shadow_row);
			end else begin
				r = place_cell(random_fields($urandom_range(0, 1) ? REQ_WRITE : REQ_READ));
			end
			send_req(r);
		end
	endtask

	// Direct cell traffic: writes of any byte and color, reads back
	task automatic test_cell_access(input int count);
		for (int n = 0; n < count; n++)
			send_req(place_cell(random_fields($urandom_range(0, 99) < 45
				? REQ_WRITE : REQ_READ)));
	endtask

	// All request types interleaved, clears included
	task automatic test_mixed_traffic(input int count);
		req_t r;
		int   pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				r = random_fields(REQ_PUT);
				r.char_code = pick_char(10);
			end else if (pick < 70) begin
				r = place_cell(random_fields(REQ_WRITE));
			end else if (pick < 96) begin
				r = place_cell(random_fields(REQ_READ));
			end else begin
				r = random_fields(REQ_CLEAR);
			end
			send_req(r);
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		// the block comes out of reset with blanks in the reset color
		shadow_color = RESET_COLOR;
		shadow_row   = 0;
		shadow_col   = 0;
		blank_screen();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_screen();
		test_put_controls();
		test_cell_extremes();
		test_clear_screen();

		set_text_color(8'h00);
		test_text_stream(250, 20);

		set_text_color(8'hFF);
		test_cell_access(200);

		set_text_color(COLOR_W'($urandom));
		test_text_stream(200, 6);

		set_text_color(COLOR_W'($urandom));
		test_mixed_traffic(300);

		wait_idle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
bench/text_console_writer_tb.sv
